// File: sv/escaped_frame_deframer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the escaped frame deframer
// Clocked, reset-gated property checks shared by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_DEFRAMER_ASSERT_SVH
`define ESCAPED_FRAME_DEFRAMER_ASSERT_SVH

// Plain invariant, checked at every clock edge out of reset.
`define EFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication, checked at every clock edge out of reset.
`define EFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: sv/efd_pkg.sv
// ----------------------------------------------------------------------------
// efd_pkg
// Constants, types and codes shared by the deframer modules.
// ----------------------------------------------------------------------------
package efd_pkg;

  // Frame store geometry
  localparam int FRAME_BYTES = 32;
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  localparam int NUM_BANKS   = 2;
  localparam int RAM_AW      = IDX_W + 1;
  localparam int RAM_DEPTH   = 1 << RAM_AW;

  // Field widths
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 6;
  localparam int CFG_IDX_W = 2;

  // Descriptor queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // ASCII '1'
  localparam logic [BYTE_W-1:0] DATA_ONE = 8'h31;

  // Register reset values
  localparam logic [BYTE_W-1:0] START_RST     = 8'd83;
  localparam logic [BYTE_W-1:0] END_RST       = 8'd69;
  localparam logic [BYTE_W-1:0] ESCAPE_RST    = 8'd92;
  localparam logic [BYTE_W-1:0] HEARTBEAT_RST = 8'd72;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START     = 2'd0,
    CFG_END       = 2'd1,
    CFG_ESCAPE    = 2'd2,
    CFG_HEARTBEAT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] end_byte;
    logic [BYTE_W-1:0] escape_byte;
    logic [BYTE_W-1:0] heartbeat_code;
  } cfg_t;

  // One completed frame, handed from front to back
  typedef struct packed {
    logic              bank;
    logic [LEN_W-1:0]  len;
    logic              is_heartbeat;
    logic              peer_ok;
    logic [BYTE_W-1:0] byte0;
  } desc_t;

  // Frame store write request from the front
  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] addr;
    logic [BYTE_W-1:0] data;
  } ram_wr_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_SEND
  } back_state_e;

endpackage

// File: sv/efd_if.sv
// ----------------------------------------------------------------------------
// efd_if
// Valid/ready stream interfaces for received bytes and frame bytes.
// ----------------------------------------------------------------------------

// Received byte stream
interface efd_rx_if;
  import efd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Completed frame byte stream
interface efd_frame_if;
  import efd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              frame_last;
  logic [LEN_W-1:0]  frame_length;
  logic              is_heartbeat;
  logic              peer_ok;

  modport source (output valid, output frame_byte, output frame_last,
                  output frame_length, output is_heartbeat, output peer_ok,
                  input ready);
  modport sink   (input valid, input frame_byte, input frame_last,
                  input frame_length, input is_heartbeat, input peer_ok,
                  output ready);
endinterface

// File: sv/escaped_frame_deframer.sv
// ----------------------------------------------------------------------------
// escaped_frame_deframer
// Reassembles start/end delimited frames with an escape byte from a byte
// stream and plays each completed frame out as a burst of items, one per
// stored byte, carrying last, length, heartbeat and peer-ok marks. The front
// end takes one received byte per cycle and writes it to one bank of a
// two-bank frame store; a closed frame is queued as a descriptor and the
// back end reads it out byte by byte: a store read, then an output step
// that holds until frame.ready is high. Input stalls only while two closed
// frames are still being read out or waiting, since both store banks are
// then taken. Configuration registers are written through
// cfg_we_i/cfg_idx_i/cfg_data_i; the store needs no clearing after reset.
// ----------------------------------------------------------------------------
module escaped_frame_deframer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  efd_rx_if.sink                           rx,
  efd_frame_if.source                      frame,
  input  logic                             cfg_we_i,
  input  logic [efd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [efd_pkg::BYTE_W-1:0]       cfg_data_i
);
  import efd_pkg::*;

  cfg_t              cfg_q;
  logic              push;
  desc_t             push_desc;
  ram_wr_t           wr;
  logic              q_valid;
  desc_t             q_desc;
  logic              pop;
  logic              done;
  logic              re;
  logic [RAM_AW-1:0] raddr;
  logic [BYTE_W-1:0] rdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte     <= START_RST;
      cfg_q.end_byte       <= END_RST;
      cfg_q.escape_byte    <= ESCAPE_RST;
      cfg_q.heartbeat_code <= HEARTBEAT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_START:     cfg_q.start_byte     <= cfg_data_i;
        CFG_END:       cfg_q.end_byte       <= cfg_data_i;
        CFG_ESCAPE:    cfg_q.escape_byte    <= cfg_data_i;
        CFG_HEARTBEAT: cfg_q.heartbeat_code <= cfg_data_i;
      endcase
    end
  end

  efd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx     (rx),
    .cfg_i  (cfg_q),
    .done_i (done),
    .push_o (push),
    .desc_o (push_desc),
    .wr_o   (wr)
  );

  efd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (push_desc),
    .pop_i   (pop),
    .valid_o (q_valid),
    .desc_o  (q_desc)
  );

  // Two-bank frame store
  efd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  efd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_desc_i  (q_desc),
    .pop_o     (pop),
    .re_o      (re),
    .raddr_o   (raddr),
    .rdata_i   (rdata),
    .frame     (frame),
    .done_o    (done)
  );

endmodule

// File: sv/efd_ram.sv
// ----------------------------------------------------------------------------
// efd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module efd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/efd_queue.sv
// ----------------------------------------------------------------------------
// efd_queue
// Short descriptor FIFO between the byte front end and the burst back end.
// ----------------------------------------------------------------------------
`include "escaped_frame_deframer_assert.svh"

module efd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  efd_pkg::desc_t desc_i,
  input  logic           pop_i,
  output logic           valid_o,
  output efd_pkg::desc_t desc_o
);
  import efd_pkg::*;

  desc_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign desc_o  = mem_q[rd_ptr_q];

  `EFD_ASSERT_IMP(a_no_push_full, push_i, count_q != QCNT_W'(QDEPTH), "queue push while full")

endmodule

// File: sv/efd_front.sv
// ----------------------------------------------------------------------------
// efd_front
// Byte classifier: framing, escape and overflow handling, frame store writes.
// ----------------------------------------------------------------------------
`include "escaped_frame_deframer_assert.svh"

module efd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  efd_rx_if.sink           rx,
  input  efd_pkg::cfg_t    cfg_i,
  input  logic             done_i,
  output logic             push_o,
  output efd_pkg::desc_t   desc_o,
  output efd_pkg::ram_wr_t wr_o
);
  import efd_pkg::*;

  localparam logic [1:0] MAX_OUT = 2'(NUM_BANKS);

  logic              in_frame_q, in_frame_d;
  logic              esc_q, esc_d;
  logic              end_seen_q, end_seen_d;
  logic [IDX_W-1:0]  widx_q, widx_d;
  logic              bank_q, bank_d;
  logic [1:0]        outst_q, outst_d;
  logic [BYTE_W-1:0] byte0_q, byte0_d;
  logic [BYTE_W-1:0] pos1_q, pos1_d;
  logic [BYTE_W-1:0] pos2_q, pos2_d;

  logic              accept;
  logic              store;
  logic [BYTE_W-1:0] b;
  logic [IDX_W:0]    nidx;
  logic              is_hb;
  logic [BYTE_W-1:0] p2_byte;

  // Stall only while both store banks hold frames not yet read out
  assign rx.ready = (outst_q != MAX_OUT);
  assign accept   = rx.valid && rx.ready;
  assign b        = rx.rx_byte;
  assign nidx     = {1'b0, widx_q} + (IDX_W+1)'(1);

  // Frame summary, taken when the closing byte arrives
  assign is_hb   = (pos1_q == cfg_i.heartbeat_code);
  assign p2_byte = (nidx == (IDX_W+1)'(2)) ? b : pos2_q;
  always_comb begin
    desc_o.bank         = bank_q;
    desc_o.len          = LEN_W'(nidx);
    desc_o.is_heartbeat = is_hb;
    desc_o.peer_ok      = is_hb && (p2_byte == DATA_ONE);
    desc_o.byte0        = byte0_q;
  end

  // Byte classification
  always_comb begin
    in_frame_d = in_frame_q;
    esc_d      = esc_q;
    end_seen_d = end_seen_q;
    widx_d     = widx_q;
    bank_d     = bank_q;
    byte0_d    = byte0_q;
    push_o     = 1'b0;
    store      = 1'b0;

    if (accept) begin
      if (!in_frame_q) begin
        if (b == cfg_i.start_byte) begin
          in_frame_d = 1'b1;
          widx_d     = '0;
          byte0_d    = b;
        end
      end else if (!end_seen_q && !esc_q && (b == cfg_i.escape_byte)) begin
        esc_d = 1'b1;
      end else if (nidx >= (IDX_W+1)'(FRAME_BYTES)) begin
        // overflow: drop the frame, byte may open the next one
        in_frame_d = (b == cfg_i.start_byte);
        esc_d      = 1'b0;
        end_seen_d = 1'b0;
        widx_d     = '0;
        if (b == cfg_i.start_byte) begin
          byte0_d = b;
        end
      end else if (esc_q) begin
        esc_d  = 1'b0;
        store  = 1'b1;
        widx_d = nidx[IDX_W-1:0];
      end else if ((b == cfg_i.start_byte) && !end_seen_q) begin
        // restart
        widx_d  = '0;
        byte0_d = b;
      end else if (end_seen_q && (b != cfg_i.end_byte)) begin
        // close: hand the frame over, closing byte may open the next one
        push_o     = 1'b1;
        bank_d     = ~bank_q;
        widx_d     = '0;
        end_seen_d = 1'b0;
        in_frame_d = (b == cfg_i.start_byte);
        if (b == cfg_i.start_byte) begin
          byte0_d = b;
        end
      end else begin
        store  = 1'b1;
        widx_d = nidx[IDX_W-1:0];
        if (!end_seen_q && (b == cfg_i.end_byte)) begin
          end_seen_d = 1'b1;
        end
      end
    end
  end

  // Store write, plus shadow copies of the flag and first data byte
  always_comb begin
    wr_o.we   = store;
    wr_o.addr = {bank_q, nidx[IDX_W-1:0]};
    wr_o.data = b;
    pos1_d    = pos1_q;
    pos2_d    = pos2_q;
    if (store && (nidx == (IDX_W+1)'(1))) begin
      pos1_d = b;
    end
    if (store && (nidx == (IDX_W+1)'(2))) begin
      pos2_d = b;
    end
  end

  // Frames in flight: pushed and not yet fully read out
  always_comb begin
    case ({push_o, done_i})
      2'b10:   outst_d = outst_q + 2'd1;
      2'b01:   outst_d = outst_q - 2'd1;
      default: outst_d = outst_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      esc_q      <= 1'b0;
      end_seen_q <= 1'b0;
      widx_q     <= '0;
      bank_q     <= 1'b0;
      outst_q    <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      esc_q      <= esc_d;
      end_seen_q <= end_seen_d;
      widx_q     <= widx_d;
      bank_q     <= bank_d;
      outst_q    <= outst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte0_q <= byte0_d;
    pos1_q  <= pos1_d;
    pos2_q  <= pos2_d;
  end

  `EFD_ASSERT_IMP(a_idle_clean, !in_frame_q, !end_seen_q && !esc_q, "marks set outside a frame")
  `EFD_ASSERT(a_outst_max, outst_q <= MAX_OUT, "too many frames in flight")
  `EFD_ASSERT_IMP(a_done_owed, done_i, outst_q != 2'd0, "frame done with none in flight")

endmodule

// File: sv/efd_back.sv
// ----------------------------------------------------------------------------
// efd_back
// Burst reader: plays a completed frame out of the store, one item per byte.
// ----------------------------------------------------------------------------
`include "escaped_frame_deframer_assert.svh"

module efd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  efd_pkg::desc_t                q_desc_i,
  output logic                          pop_o,
  output logic                          re_o,
  output logic [efd_pkg::RAM_AW-1:0]    raddr_o,
  input  logic [efd_pkg::BYTE_W-1:0]    rdata_i,
  efd_frame_if.source                   frame,
  output logic                          done_o
);
  import efd_pkg::*;

  back_state_e      state_q, state_d;
  desc_t            desc_q, desc_d;
  logic [IDX_W-1:0] k_q, k_d;
  logic             last;

  assign last    = ((LEN_W'(k_q) + LEN_W'(1)) == desc_q.len);
  assign raddr_o = {desc_q.bank, k_q};

  // Output payload: byte 0 travels in the descriptor
  assign frame.frame_byte   = (k_q == '0) ? desc_q.byte0 : rdata_i;
  assign frame.frame_last   = last;
  assign frame.frame_length = desc_q.len;
  assign frame.is_heartbeat = desc_q.is_heartbeat;
  assign frame.peer_ok      = desc_q.peer_ok;

  // Read sequencer
  always_comb begin
    state_d     = state_q;
    desc_d      = desc_q;
    k_d         = k_q;
    pop_o       = 1'b0;
    re_o        = 1'b0;
    done_o      = 1'b0;
    frame.valid = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          desc_d  = q_desc_i;
          k_d     = '0;
          state_d = BK_FETCH;
        end
      end
      BK_FETCH: begin
        re_o    = 1'b1;
        state_d = BK_SEND;
      end
      BK_SEND: begin
        frame.valid = 1'b1;
        if (frame.ready) begin
          if (last) begin
            done_o  = 1'b1;
            state_d = BK_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = BK_FETCH;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
  end

  `EFD_ASSERT_IMP(a_k_in_frame, state_q != BK_IDLE, LEN_W'(k_q) < desc_q.len, "read past frame end")

endmodule
